[hw/rtl/ibst_pkg.sv]
// Shared types, constants and helpers of the IR blob beacon servo tracker.
package ibst_pkg;

	localparam int NUM_BLOBS = 4;
	localparam int RAW_W     = 24;
	localparam int COORD_W   = 10;
	localparam int ANG_W     = 12;
	localparam int CNT_W     = 16;

	localparam logic [3:0]         SIZE_ABSENT = 4'hF;
	localparam logic [COORD_W-1:0] GAP_START   = 10'd999;
	localparam logic [ANG_W-1:0]   ANGLE_MAX   = 12'hFFF;
	localparam logic [7:0]         RECIP_FIVE  = 8'd205;

	typedef enum logic [2:0] {
		REG_CENTRE_LEFT  = 3'd0,
		REG_CENTRE_RIGHT = 3'd1,
		REG_CENTRE_TOL   = 3'd2,
		REG_PAIR_TOL     = 3'd3,
		REG_SERVO_LOWER  = 3'd4,
		REG_SERVO_UPPER  = 3'd5,
		REG_SWEEP_STEP   = 3'd6,
		REG_DEAD_ZONE    = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [COORD_W-1:0] centre_left;
		logic [COORD_W-1:0] centre_right;
		logic [COORD_W-1:0] centre_tol;
		logic [COORD_W-1:0] pair_tol;
		logic [ANG_W-1:0]   lower;
		logic [ANG_W-1:0]   upper;
		logic [COORD_W-1:0] step;
		logic [COORD_W-1:0] dead;
	} cfg_t;

	// per-camera state word
	typedef struct packed {
		logic [1:0][ANG_W-1:0] lock_angle;
		logic [1:0]            locked;
		logic                  seen;
		logic [CNT_W-1:0]      count;
		logic                  sweep_left;
		logic [ANG_W-1:0]      angle;
	} entry_t;

	typedef struct packed {
		logic [NUM_BLOBS-1:0] mask;
		logic                 centre_valid;
		logic [COORD_W-1:0]   centre_x;
		logic [ANG_W-1:0]     angle;
		logic                 seen;
		logic                 locked;
		logic [ANG_W-1:0]     lock_angle;
		logic [CNT_W-1:0]     total;
	} result_t;

	// floor(x/5) for x below 1024: reciprocal multiply
	function automatic logic [7:0] div5(input logic [COORD_W-1:0] x);
		logic [17:0] prod;
		prod = x * RECIP_FIVE;
		return prod[17:10];
	endfunction

	function automatic logic [ANG_W-1:0] sat_angle(input logic signed [15:0] v);
		logic [ANG_W-1:0] r;
		if (v < 16'sd0)
			r = '0;
		else if (v > signed'({4'd0, ANGLE_MAX}))
			r = ANGLE_MAX;
		else
			r = v[ANG_W-1:0];
		return r;
	endfunction

endpackage

[hw/rtl/ir_blob_beacon_servo_tracker.sv]
// Top level of the IR blob beacon servo tracker.
//
// One request on the slave stream is one four-blob camera report:
//   s_tuser = {beacon_kind, camera_select}, s_tdata = four 24-bit raw blobs.
// One request on the master stream is the tracker result for that report,
//   camera id in m_tuser, the rest packed in m_tdata.
// Config is an APB-style port, eight registers at 4*i, pready tied high;
//   write only while the block is idle.
// Pipeline: accept (state read issued) -> s1 pair search with the state word
//   -> s2 servo update, state written back -> output register.
// Results: an accepted request passes through s1, s2 and the output register
//   before m_tvalid rises for it. Throughput is one request per cycle while
//   the receiver keeps m_tready high: the state memory takes one read and one
//   write each cycle, with back-to-back requests to one camera served by
//   forwarding the write-back data into s1 and s2.
// At reset the config returns to its defaults and the per-camera valid bits
//   clear, so every camera starts from an all-zero state word; no sweep.
// A stalled receiver holds the output register; s2 and s1 keep filling and
//   s_tready drops only once all three stages hold a request.
module ir_blob_beacon_servo_tracker #(
	parameter int CAMERA_COUNT = 2,
	parameter int BLOB_COUNT   = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	// APB config
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	// s_tdata: blob_a_raw[23:0], blob_b_raw[47:24], blob_c_raw[71:48], blob_d_raw[95:72]
	input  logic [95:0] s_tdata,
	// s_tuser: camera_select[0], beacon_kind[1]
	input  logic [1:0]  s_tuser,
	input  logic        s_tvalid,
	output logic        s_tready,
	// m_tdata: blob_mask[3:0], centre_valid[4], centre_x[14:5], servo_angle[26:15],
	//          beacon_seen[27], beacon_locked[28], locked_angle[40:29],
	//          sweep_total[56:41], zero fill[63:57]
	output logic [63:0] m_tdata,
	// m_tuser: camera_id[0]
	output logic        m_tuser,
	output logic        m_tvalid,
	input  logic        m_tready
);
	import ibst_pkg::*;

	localparam int CAM_W = (CAMERA_COUNT > 1) ? $clog2(CAMERA_COUNT) : 1;

	// ---------------- config registers ----------------
	cfg_t     cfg_q;
	reg_idx_t widx, ridx;

	assign pready = 1'b1;
	assign widx   = reg_idx_t'(paddr[4:2]);
	assign ridx   = reg_idx_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.centre_left  <= 10'd512;
			cfg_q.centre_right <= 10'd512;
			cfg_q.centre_tol   <= 10'd20;
			cfg_q.pair_tol     <= 10'd20;
			cfg_q.lower        <= 12'd600;
			cfg_q.upper        <= 12'd2400;
			cfg_q.step         <= 10'd20;
			cfg_q.dead         <= 10'd10;
		end else if (psel && penable && pwrite && pready) begin
			case (widx)
				REG_CENTRE_LEFT:  cfg_q.centre_left  <= pwdata[COORD_W-1:0];
				REG_CENTRE_RIGHT: cfg_q.centre_right <= pwdata[COORD_W-1:0];
				REG_CENTRE_TOL:   cfg_q.centre_tol   <= pwdata[COORD_W-1:0];
				REG_PAIR_TOL:     cfg_q.pair_tol     <= pwdata[COORD_W-1:0];
				REG_SERVO_LOWER:  cfg_q.lower        <= pwdata[ANG_W-1:0];
				REG_SERVO_UPPER:  cfg_q.upper        <= pwdata[ANG_W-1:0];
				REG_SWEEP_STEP:   cfg_q.step         <= pwdata[COORD_W-1:0];
				REG_DEAD_ZONE:    cfg_q.dead         <= pwdata[COORD_W-1:0];
				default:          cfg_q              <= cfg_q;
			endcase
		end
	end

	always_comb begin
		case (ridx)
			REG_CENTRE_LEFT:  prdata = {22'd0, cfg_q.centre_left};
			REG_CENTRE_RIGHT: prdata = {22'd0, cfg_q.centre_right};
			REG_CENTRE_TOL:   prdata = {22'd0, cfg_q.centre_tol};
			REG_PAIR_TOL:     prdata = {22'd0, cfg_q.pair_tol};
			REG_SERVO_LOWER:  prdata = {20'd0, cfg_q.lower};
			REG_SERVO_UPPER:  prdata = {20'd0, cfg_q.upper};
			REG_SWEEP_STEP:   prdata = {22'd0, cfg_q.step};
			REG_DEAD_ZONE:    prdata = {22'd0, cfg_q.dead};
			default:          prdata = '0;
		endcase
	end

	// ---------------- pipeline control ----------------
	logic s1_v_q, s2_v_q, out_v_q;
	logic s1_go, s2_go, acc;

	assign s2_go    = s2_v_q && (!out_v_q || m_tready);
	assign s1_go    = s1_v_q && (!s2_v_q || s2_go);
	assign s_tready = !s1_v_q || s1_go;
	assign acc      = s_tvalid && s_tready;

	// camera index: select taken modulo the camera count
	logic [CAM_W-1:0] cam_in;
	assign cam_in = (CAMERA_COUNT > 1) ? CAM_W'(s_tuser[0]) : '0;

	// ---------------- state memory ----------------
	entry_t           ram_rdata, wdata;
	logic             ram_rvalid, we;
	logic [CAM_W-1:0] cam_s1, cam_s2;

	ibst_state_ram #(.DEPTH(CAMERA_COUNT), .AW(CAM_W)) u_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (we),
		.waddr  (cam_s2),
		.wdata  (wdata),
		.re     (acc),
		.raddr  (cam_in),
		.rdata  (ram_rdata),
		.rvalid (ram_rvalid)
	);

	// ---------------- s1: report + state word ----------------
	logic                              kind_s1;
	logic [NUM_BLOBS-1:0][RAW_W-1:0]   blobs_s1;
	entry_t                            hold_s1;
	logic                              fresh_s1;
	entry_t                            ent_s1, ent_fwd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_v_q <= 1'b0;
		else if (s_tready)
			s1_v_q <= s_tvalid;
	end

	// hold_s1 catches write-backs that land on or after the edge that issues the read
	always_ff @(posedge clk) begin
		if (acc) begin
			cam_s1   <= cam_in;
			kind_s1  <= s_tuser[1];
			blobs_s1 <= s_tdata;
			if (we && cam_s2 == cam_in) begin
				hold_s1  <= wdata;
				fresh_s1 <= 1'b0;
			end else
				fresh_s1 <= 1'b1;
		end else if (s1_v_q && we && cam_s2 == cam_s1) begin
			hold_s1  <= wdata;
			fresh_s1 <= 1'b0;
		end
	end

	assign ent_s1  = fresh_s1 ? (ram_rvalid ? ram_rdata : '0) : hold_s1;
	// write-back on the same edge as the move into s2
	assign ent_fwd = (we && cam_s2 == cam_s1) ? wdata : ent_s1;

	logic [NUM_BLOBS-1:0] mask_c;
	logic                 cv_c;
	logic [COORD_W-1:0]   cx_c;

	ibst_pair_find #(.BLOB_COUNT(BLOB_COUNT)) u_pair (
		.blobs        (blobs_s1),
		.kind         (kind_s1),
		.pair_tol     (cfg_q.pair_tol),
		.mask         (mask_c),
		.centre_valid (cv_c),
		.centre_x     (cx_c)
	);

	// ---------------- s2: servo update ----------------
	logic                 kind_s2, cv_s2;
	logic [NUM_BLOBS-1:0] mask_s2;
	logic [COORD_W-1:0]   cx_s2;
	entry_t               ent_s2;
	result_t              res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s2_v_q <= 1'b0;
		else if (!s2_v_q || s2_go)
			s2_v_q <= s1_v_q;
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			cam_s2  <= cam_s1;
			kind_s2 <= kind_s1;
			mask_s2 <= mask_c;
			cv_s2   <= cv_c;
			cx_s2   <= cx_c;
			ent_s2  <= ent_fwd;
		end
	end

	ibst_servo_upd u_upd (
		.cur          (ent_s2),
		.cam_zero     (cam_s2 == '0),
		.kind         (kind_s2),
		.mask         (mask_s2),
		.centre_valid (cv_s2),
		.centre_x     (cx_s2),
		.cfg          (cfg_q),
		.nxt          (wdata),
		.res          (res)
	);

	assign we = s2_go;

	// ---------------- output register ----------------
	logic [63:0] m_tdata_q;
	logic        m_tuser_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_v_q <= 1'b0;
		else if (!out_v_q || m_tready)
			out_v_q <= s2_v_q;
	end

	always_ff @(posedge clk) begin
		if (s2_go) begin
			m_tuser_q <= cam_s2[0];
			m_tdata_q <= {7'd0, res.total, res.lock_angle, res.locked, res.seen,
				res.angle, res.centre_x, res.centre_valid, res.mask};
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;
endmodule

[hw/rtl/ibst_state_ram.sv]
// Per-camera state memory: one write port, one registered read port, valid bits.
module ibst_state_ram #(
	parameter int DEPTH = 2,
	parameter int AW    = 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               we,
	input  logic [AW-1:0]      waddr,
	input  ibst_pkg::entry_t   wdata,
	input  logic               re,
	input  logic [AW-1:0]      raddr,
	output ibst_pkg::entry_t   rdata,
	output logic               rvalid
);
	import ibst_pkg::*;

	entry_t           mem [DEPTH];
	logic [DEPTH-1:0] vld_q;
	entry_t           rdata_q;
	logic             rvalid_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (we)
				vld_q[waddr] <= 1'b1;
			if (re)
				rvalid_q <= vld_q[raddr];
		end
	end

	assign rdata  = rdata_q;
	assign rvalid = rvalid_q;
endmodule

[hw/rtl/ibst_pair_find.sv]
// Blob unpacking and best-pair search over the camera report.
module ibst_pair_find #(
	parameter int BLOB_COUNT = 4
) (
	input  logic [ibst_pkg::NUM_BLOBS-1:0][ibst_pkg::RAW_W-1:0] blobs,
	input  logic                                              kind,
	input  logic [ibst_pkg::COORD_W-1:0]                       pair_tol,
	output logic [ibst_pkg::NUM_BLOBS-1:0]                     mask,
	output logic                                              centre_valid,
	output logic [ibst_pkg::COORD_W-1:0]                       centre_x
);
	import ibst_pkg::*;

	logic [NUM_BLOBS-1:0][COORD_W-1:0] bx, by;
	logic [NUM_BLOBS-1:0]              pres;

	always_comb begin
		for (int i = 0; i < NUM_BLOBS; i++) begin
			bx[i]   = {blobs[i][21:20], blobs[i][7:0]};
			by[i]   = {blobs[i][23:22], blobs[i][15:8]};
			pres[i] = (i < BLOB_COUNT) && (blobs[i][19:16] != SIZE_ABSENT);
		end
	end

	assign mask = pres;

	// six pairs in fixed order; a later pair wins only on a strictly smaller gap
	always_comb begin
		logic [COORD_W-1:0] best, gap;
		logic [COORD_W:0]   sum;
		best         = GAP_START;
		centre_valid = 1'b0;
		centre_x     = '0;
		for (int i = 0; i < NUM_BLOBS; i++) begin
			for (int j = i + 1; j < NUM_BLOBS; j++) begin
				if (kind)
					gap = (bx[i] > bx[j]) ? bx[i] - bx[j] : bx[j] - bx[i];
				else
					gap = (by[i] > by[j]) ? by[i] - by[j] : by[j] - by[i];
				sum = {1'b0, bx[i]} + {1'b0, bx[j]};
				if (pres[i] && pres[j] && gap < pair_tol && gap < best) begin
					best         = gap;
					centre_x     = sum[COORD_W:1];
					centre_valid = 1'b1;
				end
			end
		end
	end
endmodule

[hw/rtl/ibst_servo_upd.sv]
// Sweep, correction and lock update of one camera's state word.
module ibst_servo_upd (
	input  ibst_pkg::entry_t                cur,
	input  logic                            cam_zero,
	input  logic                            kind,
	input  logic [ibst_pkg::NUM_BLOBS-1:0]  mask,
	input  logic                            centre_valid,
	input  logic [ibst_pkg::COORD_W-1:0]    centre_x,
	input  ibst_pkg::cfg_t                  cfg,
	output ibst_pkg::entry_t                nxt,
	output ibst_pkg::result_t               res
);
	import ibst_pkg::*;

	always_comb begin
		logic signed [15:0] a, up, lo, st, dz, c, t, tol;
		logic [COORD_W-1:0] off;
		a   = signed'({4'd0, cur.angle});
		up  = signed'({4'd0, cfg.upper});
		lo  = signed'({4'd0, cfg.lower});
		st  = signed'({6'd0, cfg.step});
		dz  = signed'({6'd0, cfg.dead});
		c   = signed'({6'd0, centre_x});
		t   = signed'({6'd0, cam_zero ? cfg.centre_left : cfg.centre_right});
		tol = signed'({6'd0, cfg.centre_tol});
		off = '0;
		nxt = cur;
		if (!centre_valid) begin
			nxt.seen         = 1'b0;
			nxt.locked[kind] = 1'b0;
			// forward half, then back half, in the same update
			if ((a <<< 1) < (up <<< 1) - 16'sd3 * st && !nxt.sweep_left)
				a = signed'({4'd0, sat_angle(a + st)});
			else begin
				nxt.sweep_left = 1'b1;
				nxt.count      = nxt.count + 1'b1;
			end
			if ((a <<< 1) > (lo <<< 1) + 16'sd3 * st && nxt.sweep_left)
				a = signed'({4'd0, sat_angle(a - st)});
			else begin
				nxt.sweep_left = 1'b0;
				nxt.count      = nxt.count + 1'b1;
			end
		end else if (!(c > t - tol && c < t + tol)) begin
			nxt.seen         = 1'b1;
			nxt.locked[kind] = 1'b0;
			if (c > t) begin
				off = COORD_W'(c - t);
				if (a > lo + dz)
					a = signed'({4'd0, sat_angle(a - signed'({8'd0, div5(off)}))});
			end else begin
				off = COORD_W'(t - c);
				if (a < up - dz)
					a = signed'({4'd0, sat_angle(a + signed'({8'd0, div5(off)}))});
			end
		end else begin
			nxt.lock_angle[kind] = cur.angle;
			nxt.locked[kind]     = 1'b1;
		end
		nxt.angle = a[ANG_W-1:0];

		res.mask         = mask;
		res.centre_valid = centre_valid;
		res.centre_x     = centre_valid ? centre_x : '0;
		res.angle        = nxt.angle;
		res.seen         = nxt.seen;
		res.locked       = nxt.locked[kind];
		res.lock_angle   = nxt.lock_angle[kind];
		res.total        = nxt.count;
	end
endmodule

[hw/rtl/ibst_checker.sv]
// Port-level checks of the tracker result stream, bound to the top level.
module ibst_checker (
	input logic        clk,
	input logic        arst_n,
	input logic [63:0] m_tdata,
	input logic        m_tvalid,
	input logic        m_tready
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_lock_angle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[28] |-> m_tdata[26:15] == m_tdata[40:29])
		else $error("locked result with angle differing from lock angle");

	a_no_centre: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[4] |-> m_tdata[14:5] == 10'd0 && !m_tdata[27] && !m_tdata[28])
		else $error("result without centre reports centre, seen or lock");

	a_pair_mask: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[4] |-> $countones(m_tdata[3:0]) >= 2)
		else $error("centre found with fewer than two blobs present");
endmodule

bind ir_blob_beacon_servo_tracker ibst_checker u_ibst_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tdata  (m_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready)
);

[tb/tb_ir_blob_beacon_servo_tracker.sv]
// Self-checking testbench for the IR blob beacon servo tracker: random and directed camera reports.
`timescale 1ns / 1ps

module tb_ir_blob_beacon_servo_tracker;
	import ibst_pkg::*;

	typedef struct packed {
		logic              cam;
		logic [3:0]        mask;
		logic              cvalid;
		logic [9:0]        cx;
		logic [11:0]       angle;
		logic              seen;
		logic              locked;
		logic [11:0]       lock_angle;
		logic [15:0]       total;
	} track_t;

	typedef struct packed {
		logic        kind;
		logic        cam;
		logic [95:0] blobs;
	} report_t;

	logic clk, arst_n;
	logic psel, penable, pwrite;
	logic [4:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;
	logic [95:0] s_tdata;
	logic [1:0] s_tuser;
	logic s_tvalid, s_tready;
	logic [63:0] m_tdata;
	logic m_tuser, m_tvalid, m_tready;

	ir_blob_beacon_servo_tracker DUT (.*);

	// clock, 4 ns period
	always begin
		clk = 1'b0; #2;
		clk = 1'b1; #2;
	end

	// predictor state: configuration and per-camera tracking
	int unsigned cfg_val [8];
	int unsigned ang_st [2];
	bit          swl [2];
	int unsigned sweeps [2];
	bit          seen_st [2];
	bit          lock_st [2][2];
	int unsigned lock_ang [2][2];

	report_t pending_reports [$];
	track_t  expected_tracks [$];

	int errors = 0;
	int mismatches = 0;
	int send_idle_pct = 0, recv_idle_pct = 0;
	int hold_off = 0;   // receiver hold-off cycles left
	int quiet = 0;      // watchdog: cycles without a handshake on either stream

	function automatic int sat12(int v);
		if (v < 0) return 0;
		if (v > 4095) return 4095;
		return v;
	endfunction

	// work out the tracker result of one report and advance the model state
	function automatic track_t track_report(report_t r);
		track_t t;
		int c, k, i, j, gap, best, centre, a, tgt, tol;
		int bx [4], by [4];
		bit pres [4];
		bit ok;
		int unsigned lo, up, st, dz;
		c = r.cam; k = r.kind;
		lo = cfg_val[REG_SERVO_LOWER]; up = cfg_val[REG_SERVO_UPPER];
		st = cfg_val[REG_SWEEP_STEP]; dz = cfg_val[REG_DEAD_ZONE];
		t = '0;
		for (i = 0; i < 4; i++) begin
			logic [23:0] raw;
			raw = r.blobs[24*i +: 24];
			bx[i] = raw[7:0] + (raw[21:20] << 8);
			by[i] = raw[15:8] + (raw[23:22] << 8);
			pres[i] = raw[19:16] != 4'hF;
			t.mask[i] = pres[i];
		end
		best = 999; ok = 0; centre = 0;
		for (i = 0; i < 4; i++)
			for (j = i + 1; j < 4; j++) begin
				if (!pres[i] || !pres[j]) continue;
				gap = k ? ((bx[i] > bx[j]) ? bx[i] - bx[j] : bx[j] - bx[i])
					: ((by[i] > by[j]) ? by[i] - by[j] : by[j] - by[i]);
				if (gap < int'(cfg_val[REG_PAIR_TOL]) && gap < best) begin
					best = gap;
					centre = (bx[i] + bx[j]) / 2;
					ok = 1;
				end
			end
		a = ang_st[c];
		if (!ok) begin
			// sweep: forward half then back half
			seen_st[c] = 0;
			lock_st[c][k] = 0;
			if (2*a < 2*int'(up) - 3*int'(st) && !swl[c]) a = sat12(a + st);
			else begin
				swl[c] = 1;
				sweeps[c] = (sweeps[c] + 1) & 16'hFFFF;
			end
			if (2*a > 2*int'(lo) + 3*int'(st) && swl[c]) a = sat12(a - st);
			else begin
				swl[c] = 0;
				sweeps[c] = (sweeps[c] + 1) & 16'hFFFF;
			end
		end else begin
			tgt = c ? cfg_val[REG_CENTRE_RIGHT] : cfg_val[REG_CENTRE_LEFT];
			tol = cfg_val[REG_CENTRE_TOL];
			if (!(centre > tgt - tol && centre < tgt + tol)) begin
				seen_st[c] = 1;
				lock_st[c][k] = 0;
				if (centre > tgt) begin
					if (a > int'(lo + dz)) a = sat12(a - (centre - tgt) / 5);
				end else if (a < int'(up) - int'(dz)) begin
					a = sat12(a + (tgt - centre) / 5);
				end
			end else begin
				lock_ang[c][k] = a;
				lock_st[c][k] = 1;
			end
		end
		ang_st[c] = a;
		t.cam = r.cam;
		t.cvalid = ok;
		t.cx = ok ? 10'(centre) : '0;
		t.angle = 12'(a);
		t.seen = seen_st[c];
		t.locked = lock_st[c][k];
		t.lock_angle = 12'(lock_ang[c][k]);
		t.total = 16'(sweeps[c]);
		return t;
	endfunction

	// driver: pops the pending reports, idles at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= '0;
		end else if (!s_tvalid || s_tready) begin
			if (pending_reports.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				report_t r;
				r = pending_reports.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= r.blobs;
				s_tuser  <= {r.kind, r.cam};
				expected_tracks.push_back(track_report(r));
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// receiver readiness, with optional long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= $urandom_range(99) >= recv_idle_pct;
		end
	end

	// monitor: compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			track_t got, want;
			got.cam        = m_tuser;
			got.mask       = m_tdata[3:0];
			got.cvalid     = m_tdata[4];
			got.cx         = m_tdata[14:5];
			got.angle      = m_tdata[26:15];
			got.seen       = m_tdata[27];
			got.locked     = m_tdata[28];
			got.lock_angle = m_tdata[40:29];
			got.total      = m_tdata[56:41];
			if (expected_tracks.size() == 0) begin
				errors++;
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h", got);
			end else begin
				want = expected_tracks.pop_front();
				if (got !== want || m_tdata[63:57] !== '0) begin
					errors++;
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp cam %0d mask %h cv %0d cx %0d ang %0d seen %0d lk %0d lka %0d tot %0d | got cam %0d mask %h cv %0d cx %0d ang %0d seen %0d lk %0d lka %0d tot %0d",
							want.cam, want.mask, want.cvalid, want.cx, want.angle, want.seen,
							want.locked, want.lock_angle, want.total,
							got.cam, got.mask, got.cvalid, got.cx, got.angle, got.seen,
							got.locked, got.lock_angle, got.total);
				end
			end
		end
	end

	// watchdog on stalled handshakes
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
		else quiet <= quiet + 1;
		if (quiet > 20000) begin
			$display("ir_blob_beacon_servo_tracker verification failed");
			$finish;
		end
	end

	// one APB register write, setup then access
	task automatic write_reg(reg_idx_t idx, int unsigned value);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= 5'(idx) << 2; pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		cfg_val[idx] = value;
	endtask

	task automatic wait_drained();
		while (pending_reports.size() != 0 || expected_tracks.size() != 0 || s_tvalid)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// one blob in the three-byte camera layout
	function automatic logic [23:0] blob(int x, int y, int sz);
		logic [9:0] xv, yv;
		xv = 10'(x); yv = 10'(y);
		return {yv[9:8], xv[9:8], 4'(sz), yv[7:0], xv[7:0]};
	endfunction

	function automatic logic [23:0] rand_blob();
		return $urandom_range(3) == 0 ? 24'($urandom) : blob($urandom_range(1023),
			$urandom_range(1023), $urandom_range(15));
	endfunction

	// a report built around a beacon pair near a centre column
	function automatic report_t beacon_report(int near);
		report_t r;
		int x, y, g, p, q;
		r.cam = 1'($urandom_range(1)); r.kind = 1'($urandom_range(1));
		for (int i = 0; i < 4; i++) r.blobs[24*i +: 24] = rand_blob();
		x = near + int'($urandom_range(200)) - 100;
		if (x < 0) x = 0;
		if (x > 1000) x = 1000;
		y = $urandom_range(1000);
		g = $urandom_range(24);
		p = $urandom_range(3); q = (p + 1 + $urandom_range(2)) % 4;
		r.blobs[24*p +: 24] = blob(x, y, $urandom_range(14));
		r.blobs[24*q +: 24] = r.kind ? blob(x + g, y + 300, $urandom_range(14))
			: blob(x + 20, y + g, $urandom_range(14));
		return r;
	endfunction

	task automatic run_random(int n, int near);
		report_t r;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(9) < 7) r = beacon_report(near);
			else begin
				r.cam = 1'($urandom_range(1)); r.kind = 1'($urandom_range(1));
				for (int b = 0; b < 4; b++) r.blobs[24*b +: 24] = rand_blob();
			end
			pending_reports.push_back(r);
		end
	endtask

	initial begin
		report_t r;
		psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
		cfg_val = '{512, 512, 20, 20, 600, 2400, 20, 10};
		ang_st = '{0, 0}; swl = '{0, 0}; sweeps = '{0, 0}; seen_st = '{0, 0};
		lock_st = '{'{0, 0}, '{0, 0}}; lock_ang = '{'{0, 0}, '{0, 0}};
		send_idle_pct = 32; recv_idle_pct = 52;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed: all absent, extremes, ties, locked centre, both kinds
		r.cam = 0; r.kind = 0; r.blobs = '1;
		pending_reports.push_back(r);
		r.blobs = '0;                                 // all present, all coincident
		pending_reports.push_back(r);
		r.cam = 1; r.kind = 1;
		r.blobs = {blob(1023, 1023, 14), blob(1023, 0, 14), blob(0, 1023, 0), blob(0, 0, 0)};
		pending_reports.push_back(r);
		r.kind = 0;
		r.blobs = {blob(520, 100, 1), blob(500, 105, 2), blob(512, 50, 15), blob(512, 52, 3)};
		pending_reports.push_back(r);
		r.cam = 0;                                    // pair gaps equal: first pair wins
		r.blobs = {blob(700, 10, 0), blob(100, 13, 0), blob(900, 500, 0), blob(300, 503, 0)};
		pending_reports.push_back(r);
		for (int i = 0; i < 12; i++) begin
			r.cam = i[0]; r.kind = i[1];
			r.blobs = {24'hFFFFFF, 24'hFFFFFF, blob(510, 400, 5), blob(514, 401, 5)};
			pending_reports.push_back(r);
		end
		for (int i = 0; i < 6; i++) begin
			r.cam = i[0]; r.kind = 1;
			r.blobs = {24'hFFFFFF, blob(100, 0, 0), blob(950, 300, 7), blob(960, 900, 7)};
			pending_reports.push_back(r);
		end
		wait_drained();

		// phase 1: sender idles more rarely, receiver often; one long hold-off
		hold_off <= 300;
		run_random(500, 512);
		wait_drained();

		// extremes of the registers
		write_reg(REG_CENTRE_LEFT, 1023);
		write_reg(REG_CENTRE_RIGHT, 0);
		write_reg(REG_CENTRE_TOL, 1023);
		write_reg(REG_PAIR_TOL, 1023);
		write_reg(REG_SERVO_LOWER, 4095);
		write_reg(REG_SERVO_UPPER, 0);
		write_reg(REG_SWEEP_STEP, 1023);
		write_reg(REG_DEAD_ZONE, 1023);
		send_idle_pct = 52; recv_idle_pct = 32;
		run_random(150, 512);
		wait_drained();

		write_reg(REG_CENTRE_TOL, 0);
		write_reg(REG_PAIR_TOL, 0);
		write_reg(REG_SERVO_LOWER, 0);
		write_reg(REG_SERVO_UPPER, 4095);
		write_reg(REG_SWEEP_STEP, 0);
		write_reg(REG_DEAD_ZONE, 0);
		run_random(150, 0);
		wait_drained();

		// phase 3: moderate settings, no idling
		write_reg(REG_CENTRE_LEFT, 300);
		write_reg(REG_CENTRE_RIGHT, 700);
		write_reg(REG_CENTRE_TOL, 30);
		write_reg(REG_PAIR_TOL, 25);
		write_reg(REG_SERVO_LOWER, 100);
		write_reg(REG_SERVO_UPPER, 3900);
		write_reg(REG_SWEEP_STEP, 700);
		write_reg(REG_DEAD_ZONE, 5);
		send_idle_pct = 0; recv_idle_pct = 0;
		run_random(300, 500);
		wait_drained();
		write_reg(REG_SWEEP_STEP, 37);
		run_random(400, 500);
		wait_drained();

		if (errors == 0)
			$display("ir_blob_beacon_servo_tracker verification clean");
		else
			$display("ir_blob_beacon_servo_tracker verification failed");
		$finish;
	end
endmodule

[ir_blob_beacon_servo_tracker.f]
hw/rtl/ibst_pkg.sv
hw/rtl/ibst_state_ram.sv
hw/rtl/ibst_pair_find.sv
hw/rtl/ibst_servo_upd.sv
hw/rtl/ir_blob_beacon_servo_tracker.sv
hw/rtl/ibst_checker.sv
tb/tb_ir_blob_beacon_servo_tracker.sv
